FILE: hdl/bsm_pkg.sv
// Box suppression with merge: shared types, codes and helper functions.
// No dependencies; bsm_iou, the top level and the bench package import this package.
package bsm_pkg;

  // Input commands
  typedef enum logic [1:0] {
    CMD_DETECT = 2'd0,
    CMD_READ   = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  // Result status codes
  typedef enum logic [2:0] {
    STS_KEPT       = 3'd0,
    STS_SUPPRESSED = 3'd1,
    STS_DROPPED    = 3'd2,
    STS_READ       = 3'd3,
    STS_BAD_INDEX  = 3'd4,
    STS_CLEARED    = 3'd5
  } status_e;

  // Control sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_SCAN,
    S_DRAIN,
    S_FINAL,
    S_EMIT
  } fsm_e;

  // Configuration register indexes (word address)
  localparam logic [1:0] REG_NMS_THR   = 2'd0;
  localparam logic [1:0] REG_MERGE_IOU = 2'd1;
  localparam logic [1:0] REG_MERGE_GAP = 2'd2;
  localparam logic [1:0] REG_KEEP_LIM  = 2'd3;

  localparam int unsigned CORNERS = 4;
  localparam int unsigned SUM_W   = 48;
  // geometry word: rect(50) area(24) conf(16) label(4)
  localparam int unsigned GEO_W   = 94;
  // sums word: four corner sums and the set count
  localparam int unsigned SUMS_W  = CORNERS * SUM_W + 8;

  typedef struct packed {
    logic signed [12:0]  rect_left;
    logic signed [12:0]  rect_top;
    logic [11:0]         rect_width;
    logic [11:0]         rect_height;
    logic [15:0]         confidence;
    logic [3:0]          label;
    logic [3:0][31:0]    corner;
  } det_t;

  typedef struct packed {
    logic [2:0]          status;
    logic [6:0]          entry_index;
    logic [7:0]          set_count;
    logic [3:0][47:0]    corner_sum;
    logic [15:0]         entry_confidence;
    logic [3:0]          entry_label;
  } res_t;

  // Status from the overlap unit to the sequencer
  typedef struct packed {
    logic valid;
    logic busy;
    logic suppress;
    logic merge;
  } scan_t;

  // Packed Q12.4 corner to packed 24-bit halves
  function automatic logic [47:0] widen_corner(logic [31:0] c);
    return {{8{c[31]}}, c[31:16], {8{c[15]}}, c[15:0]};
  endfunction

  // Halves wrap independently modulo 2^24
  function automatic logic [47:0] add_sum(logic [47:0] s, logic [31:0] c);
    logic [47:0] t;
    logic [23:0] x;
    logic [23:0] y;
    t = widen_corner(c);
    x = s[47:24] + t[47:24];
    y = s[23:0] + t[23:0];
    return {x, y};
  endfunction

endpackage

FILE: hdl/bsm_in_if.sv
// Input channel of the box suppression block: valid/ready plus one detection.
// Depends on nothing.
interface bsm_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic [6:0]         read_index;
  logic signed [12:0] rect_left;
  logic signed [12:0] rect_top;
  logic [11:0]        rect_width;
  logic [11:0]        rect_height;
  logic [15:0]        confidence;
  logic [3:0]         label;
  logic [31:0]        corner0;
  logic [31:0]        corner1;
  logic [31:0]        corner2;
  logic [31:0]        corner3;

  modport source (
    output valid, command, read_index, rect_left, rect_top, rect_width, rect_height,
           confidence, label, corner0, corner1, corner2, corner3,
    input  ready
  );
  modport sink (
    input  valid, command, read_index, rect_left, rect_top, rect_width, rect_height,
           confidence, label, corner0, corner1, corner2, corner3,
    output ready
  );
endinterface

FILE: hdl/bsm_out_if.sv
// Result channel of the box suppression block: valid/ready plus one result.
// Depends on nothing.
interface bsm_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [6:0]  entry_index;
  logic [7:0]  set_count;
  logic [47:0] corner0_sum;
  logic [47:0] corner1_sum;
  logic [47:0] corner2_sum;
  logic [47:0] corner3_sum;
  logic [15:0] entry_confidence;
  logic [3:0]  entry_label;

  modport source (
    output valid, status, entry_index, set_count, corner0_sum, corner1_sum,
           corner2_sum, corner3_sum, entry_confidence, entry_label,
    input  ready
  );
  modport sink (
    input  valid, status, entry_index, set_count, corner0_sum, corner1_sum,
           corner2_sum, corner3_sum, entry_confidence, entry_label,
    output ready
  );
endinterface

FILE: hdl/bsm_ram.sv
// Generic simple dual-port RAM, one write and one read port, registered read.
// Depends on nothing.
module bsm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end
endmodule

FILE: hdl/bsm_iou.sv
// Overlap unit: three-stage IoU test of the held detection against one kept
// entry per cycle. Depends on bsm_pkg.
module bsm_iou
  import bsm_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     rd_valid_i,
  input  logic [(TABLE_DEPTH > 1 ? $clog2(TABLE_DEPTH) : 1)-1:0] rd_idx_i,
  input  logic [GEO_W-1:0]         geo_i,
  input  det_t                     det_i,
  input  logic [23:0]              det_area_i,
  input  logic [10:0]              nms_thr_i,
  input  logic [10:0]              merge_iou_i,
  input  logic [15:0]              merge_gap_i,
  output scan_t                    scan_o,
  output logic [(TABLE_DEPTH > 1 ? $clog2(TABLE_DEPTH) : 1)-1:0] scan_idx_o
);
  localparam int unsigned AW = TABLE_DEPTH > 1 ? $clog2(TABLE_DEPTH) : 1;

  // stage B: intersection extents and attribute match
  logic signed [13:0] l_s, r_s, t_s, b_s, kl_s, kr_s, kt_s, kb_s;
  logic signed [13:0] x1, x2, y1, y2;
  logic signed [14:0] dx, dy;
  logic [15:0]        kconf, gap;
  logic               attr_ok;

  logic               b_v_q, c_v_q;
  logic [AW-1:0]      b_idx_q, c_idx_q;
  logic [11:0]        dx_q, dy_q;
  logic [23:0]        b_area_q, c_area_q;
  logic               b_attr_q, c_attr_q;
  logic [23:0]        inter_q;

  always_comb begin
    l_s  = {det_i.rect_left[12], det_i.rect_left};
    t_s  = {det_i.rect_top[12], det_i.rect_top};
    r_s  = l_s + $signed({2'b00, det_i.rect_width});
    b_s  = t_s + $signed({2'b00, det_i.rect_height});
    kl_s = $signed({geo_i[93], geo_i[93:81]});
    kt_s = $signed({geo_i[80], geo_i[80:68]});
    kr_s = kl_s + $signed({2'b00, geo_i[67:56]});
    kb_s = kt_s + $signed({2'b00, geo_i[55:44]});
    x1   = (l_s > kl_s) ? l_s : kl_s;
    y1   = (t_s > kt_s) ? t_s : kt_s;
    x2   = (r_s < kr_s) ? r_s : kr_s;
    y2   = (b_s < kb_s) ? b_s : kb_s;
    dx   = {x2[13], x2} - {x1[13], x1};
    dy   = {y2[13], y2} - {y1[13], y1};
    kconf = geo_i[19:4];
    gap   = (det_i.confidence > kconf) ? det_i.confidence - kconf
                                       : kconf - det_i.confidence;
    attr_ok = (gap < merge_gap_i) && (det_i.label == geo_i[3:0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
    end else begin
      b_v_q <= rd_valid_i;
      c_v_q <= b_v_q;
    end
  end

  // empty extent clamps to zero, which empties the intersection
  always_ff @(posedge clk_i) begin
    b_idx_q  <= rd_idx_i;
    dx_q     <= (!dx[14] && dx != '0) ? dx[11:0] : '0;
    dy_q     <= (!dy[14] && dy != '0) ? dy[11:0] : '0;
    b_area_q <= geo_i[43:20];
    b_attr_q <= attr_ok;
    // stage C: intersection area
    c_idx_q  <= b_idx_q;
    inter_q  <= dx_q * dy_q;
    c_area_q <= b_area_q;
    c_attr_q <= b_attr_q;
  end

  // stage D: union and cross-multiplied threshold tests
  logic [24:0] uni;
  logic [35:0] lhs, rhs_nms, rhs_mrg;
  logic        zero_uni;
  logic        sc_v_q, sc_sup_q, sc_mrg_q;

  always_comb begin
    uni      = {1'b0, det_area_i} + {1'b0, c_area_q} - {1'b0, inter_q};
    zero_uni = (uni == '0);
    lhs      = {2'b00, inter_q, 10'b0};
    rhs_nms  = nms_thr_i * uni;
    rhs_mrg  = merge_iou_i * uni;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sc_v_q <= 1'b0;
    end else begin
      sc_v_q <= c_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sc_sup_q   <= zero_uni || (lhs > rhs_nms);
    sc_mrg_q   <= !zero_uni && (lhs > rhs_nms) && (lhs > rhs_mrg) && c_attr_q;
    scan_idx_o <= c_idx_q;
  end

  assign scan_o = '{valid: sc_v_q, busy: b_v_q || c_v_q, suppress: sc_sup_q,
                    merge: sc_mrg_q};
endmodule

FILE: hdl/box_suppression_with_merge.sv
// Box suppression with merge, top level: sequencer, tables and config port.
// Depends on bsm_pkg, bsm_in_if, bsm_out_if, bsm_ram and bsm_iou.
//
// Usage: detections enter on det_i (valid/ready), sorted by falling
// confidence; one result per transaction leaves on res_o (valid/ready).
// Command clear starts a frame, command read returns a kept entry's corner
// sums, set count, confidence and label; command 3 gives no result.
// A detection is compared with every kept entry, one entry per cycle, through
// a read/test/merge pipeline over two one-port-read RAMs (geometry and sums);
// with an empty table the scan is skipped. One transaction is worked on at a
// time; det_i.ready is high while the sequencer is idle, also while a result
// waits in the output register. When the receiver stalls, the finished result
// holds and the next one waits until the output register frees.
// Reset empties the table (kept and seen counts to zero) and loads the
// register defaults; the RAMs are not cleared, so no clearing pass is run.
// Config registers (APB, word address): 0 suppression IoU threshold,
// 1 merge_min_iou, 2 merge_conf_gap, 3 keep_limit. Write them only while idle.
module box_suppression_with_merge
  import bsm_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 128
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  bsm_in_if.sink       det_i,
  bsm_out_if.source    res_o,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  localparam int unsigned AW = TABLE_DEPTH > 1 ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  // config registers
  logic [10:0] nms_thr_q, merge_iou_q;
  logic [15:0] merge_gap_q;
  logic [7:0]  keep_lim_q;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nms_thr_q   <= 11'd307;
      merge_iou_q <= 11'd922;
      merge_gap_q <= 16'd9830;
      keep_lim_q  <= 8'd128;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_NMS_THR:   nms_thr_q   <= pwdata[10:0];
        REG_MERGE_IOU: merge_iou_q <= pwdata[10:0];
        REG_MERGE_GAP: merge_gap_q <= pwdata[15:0];
        REG_KEEP_LIM:  keep_lim_q  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_NMS_THR:   prdata = {21'b0, nms_thr_q};
      REG_MERGE_IOU: prdata = {21'b0, merge_iou_q};
      REG_MERGE_GAP: prdata = {16'b0, merge_gap_q};
      REG_KEEP_LIM:  prdata = {24'b0, keep_lim_q};
      default:       prdata = '0;
    endcase
  end

  // sequencer state and held transaction
  fsm_e          state_q, state_d;
  logic [CW-1:0] kept_q;
  logic [7:0]    seen_q;
  det_t          det_q, det_in;
  logic [23:0]   area_q;
  logic [6:0]    rd_index_q;
  logic [AW-1:0] scan_q;
  logic          rd_v_q;
  logic [AW-1:0] rd_idx_q;
  logic          keep_q;
  logic [AW-1:0] first_q;
  logic          e_v_q, e_sup_q, e_mrg_q;
  logic [AW-1:0] e_idx_q;
  res_t          pend_q, out_q;
  logic          out_v_q;

  logic accept, read_ok, at_limit, last_issue, drained, room, out_free;
  scan_t         scan;
  logic [AW-1:0] scan_idx;

  // memory ports
  logic              geo_re, geo_we, sum_re, sum_we;
  logic [AW-1:0]     geo_raddr, sum_raddr, sum_waddr;
  logic [GEO_W-1:0]  geo_rdata, geo_wdata;
  logic [SUMS_W-1:0] sum_rdata, sum_wdata, sum_merged, sum_new;

  assign det_i.ready = (state_q == S_IDLE);
  assign accept      = det_i.valid && det_i.ready;
  assign read_ok     = 32'(det_i.read_index) < 32'(kept_q);
  assign at_limit    = seen_q >= keep_lim_q;
  assign last_issue  = (CW'(scan_q) + CW'(1)) == kept_q;
  assign drained     = !rd_v_q && !scan.busy && !scan.valid && !e_v_q;
  assign room        = 32'(kept_q) < TABLE_DEPTH;
  assign out_free    = !out_v_q || res_o.ready;

  always_comb begin
    det_in.rect_left   = det_i.rect_left;
    det_in.rect_top    = det_i.rect_top;
    det_in.rect_width  = det_i.rect_width;
    det_in.rect_height = det_i.rect_height;
    det_in.confidence  = det_i.confidence;
    det_in.label       = det_i.label;
    det_in.corner[0]   = det_i.corner0;
    det_in.corner[1]   = det_i.corner1;
    det_in.corner[2]   = det_i.corner2;
    det_in.corner[3]   = det_i.corner3;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (cmd_e'(det_i.command))
            CMD_CLEAR:  state_d = S_EMIT;
            CMD_READ:   state_d = read_ok ? S_READ : S_EMIT;
            CMD_DETECT: begin
              if (at_limit) state_d = S_EMIT;
              else if (kept_q == '0) state_d = S_FINAL;
              else state_d = S_SCAN;
            end
            default:    state_d = S_IDLE;
          endcase
        end
      end
      S_READ:  state_d = S_EMIT;
      S_SCAN:  state_d = last_issue ? S_DRAIN : S_SCAN;
      S_DRAIN: state_d = drained ? S_FINAL : S_DRAIN;
      S_FINAL: state_d = S_EMIT;
      S_EMIT:  state_d = out_free ? S_IDLE : S_EMIT;
      default: state_d = S_IDLE;
    endcase
  end

  // memory control: scan and read-command reads, merge write-back, new entry write
  always_comb begin
    geo_re    = 1'b0;
    geo_raddr = scan_q;
    sum_re    = 1'b0;
    sum_raddr = scan_idx;
    if (state_q == S_IDLE && accept && det_i.command == CMD_READ && read_ok) begin
      geo_re    = 1'b1;
      geo_raddr = AW'(det_i.read_index);
      sum_re    = 1'b1;
      sum_raddr = AW'(det_i.read_index);
    end else begin
      geo_re = (state_q == S_SCAN);
      sum_re = scan.valid;
    end
    for (int c = 0; c < CORNERS; c++) begin
      sum_merged[8 + SUM_W*(CORNERS-1-c) +: SUM_W] =
        add_sum(sum_rdata[8 + SUM_W*(CORNERS-1-c) +: SUM_W], det_q.corner[c]);
      sum_new[8 + SUM_W*(CORNERS-1-c) +: SUM_W] = widen_corner(det_q.corner[c]);
    end
    sum_merged[7:0] = (sum_rdata[7:0] == 8'hFF) ? 8'hFF : sum_rdata[7:0] + 8'd1;
    sum_new[7:0]    = 8'd1;
    geo_wdata = {det_q.rect_left, det_q.rect_top, det_q.rect_width, det_q.rect_height,
                 area_q, det_q.confidence, det_q.label};
    geo_we    = (state_q == S_FINAL) && keep_q && room;
    sum_we    = geo_we || (e_v_q && e_mrg_q);
    sum_waddr = geo_we ? AW'(kept_q) : e_idx_q;
    sum_wdata = geo_we ? sum_new : sum_merged;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      kept_q  <= '0;
      seen_q  <= '0;
      rd_v_q  <= 1'b0;
      e_v_q   <= 1'b0;
      keep_q  <= 1'b1;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      rd_v_q  <= (state_q == S_SCAN);
      e_v_q   <= scan.valid;
      if (accept && det_i.command == CMD_CLEAR) begin
        kept_q <= '0;
        seen_q <= '0;
      end
      if (accept && det_i.command == CMD_DETECT && !at_limit) begin
        keep_q <= 1'b1;
        if (seen_q != 8'hFF) seen_q <= seen_q + 8'd1;
      end else if (e_v_q && e_sup_q) begin
        keep_q <= 1'b0;
      end
      if (geo_we) kept_q <= kept_q + CW'(1);
      if (state_q == S_EMIT && out_free) out_v_q <= 1'b1;
      else if (res_o.ready) out_v_q <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      det_q      <= det_in;
      area_q     <= det_i.rect_width * det_i.rect_height;
      rd_index_q <= det_i.read_index;
      scan_q     <= '0;
    end else if (state_q == S_SCAN) begin
      scan_q <= scan_q + AW'(1);
    end
    rd_idx_q <= scan_q;
    e_sup_q  <= scan.suppress;
    e_mrg_q  <= scan.merge;
    e_idx_q  <= scan_idx;
    // lowest suppressing entry wins
    if (e_v_q && e_sup_q && keep_q) first_q <= e_idx_q;

    if (accept) begin
      case (cmd_e'(det_i.command))
        CMD_CLEAR:  pend_q <= '{status: STS_CLEARED, default: '0};
        CMD_READ:   pend_q <= '{status: STS_BAD_INDEX, entry_index: det_i.read_index,
                                default: '0};
        CMD_DETECT: pend_q <= '{status: STS_DROPPED, default: '0};
        default:    pend_q <= '0;
      endcase
    end else if (state_q == S_READ) begin
      pend_q.status           <= STS_READ;
      pend_q.entry_index      <= rd_index_q;
      pend_q.set_count        <= sum_rdata[7:0];
      pend_q.corner_sum[0]    <= sum_rdata[199:152];
      pend_q.corner_sum[1]    <= sum_rdata[151:104];
      pend_q.corner_sum[2]    <= sum_rdata[103:56];
      pend_q.corner_sum[3]    <= sum_rdata[55:8];
      pend_q.entry_confidence <= geo_rdata[19:4];
      pend_q.entry_label      <= geo_rdata[3:0];
    end else if (state_q == S_FINAL) begin
      if (!keep_q) begin
        pend_q.status      <= STS_SUPPRESSED;
        pend_q.entry_index <= 7'(first_q);
      end else if (room) begin
        pend_q.status      <= STS_KEPT;
        pend_q.entry_index <= 7'(kept_q);
      end
    end
    if (state_q == S_EMIT && out_free) out_q <= pend_q;
  end

  bsm_ram #(.WIDTH(GEO_W), .DEPTH(TABLE_DEPTH)) u_geo_ram (
    .clk_i   (clk_i),
    .we_i    (geo_we),
    .waddr_i (AW'(kept_q)),
    .wdata_i (geo_wdata),
    .re_i    (geo_re),
    .raddr_i (geo_raddr),
    .rdata_o (geo_rdata)
  );

  bsm_ram #(.WIDTH(SUMS_W), .DEPTH(TABLE_DEPTH)) u_sum_ram (
    .clk_i   (clk_i),
    .we_i    (sum_we),
    .waddr_i (sum_waddr),
    .wdata_i (sum_wdata),
    .re_i    (sum_re),
    .raddr_i (sum_raddr),
    .rdata_o (sum_rdata)
  );

  bsm_iou #(.TABLE_DEPTH(TABLE_DEPTH)) u_iou (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_valid_i  (rd_v_q),
    .rd_idx_i    (rd_idx_q),
    .geo_i       (geo_rdata),
    .det_i       (det_q),
    .det_area_i  (area_q),
    .nms_thr_i   (nms_thr_q),
    .merge_iou_i (merge_iou_q),
    .merge_gap_i (merge_gap_q),
    .scan_o      (scan),
    .scan_idx_o  (scan_idx)
  );

  // result channel
  assign res_o.valid            = out_v_q;
  assign res_o.status           = out_q.status;
  assign res_o.entry_index      = out_q.entry_index;
  assign res_o.set_count        = out_q.set_count;
  assign res_o.corner0_sum      = out_q.corner_sum[0];
  assign res_o.corner1_sum      = out_q.corner_sum[1];
  assign res_o.corner2_sum      = out_q.corner_sum[2];
  assign res_o.corner3_sum      = out_q.corner_sum[3];
  assign res_o.entry_confidence = out_q.entry_confidence;
  assign res_o.entry_label      = out_q.entry_label;

  // checks
  a_kept_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(kept_q) <= TABLE_DEPTH) else $error("kept count beyond table depth");

  a_merge_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    e_v_q |-> (state_q == S_SCAN || state_q == S_DRAIN))
    else $error("merge stage active outside a scan");

  a_kept_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (kept_q != $past(kept_q)) |-> (kept_q == '0 || kept_q == $past(kept_q) + CW'(1)))
    else $error("kept count moved by more than one");

  a_scan_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (kept_q != '0))
    else $error("scan started on an empty table");
endmodule

FILE: tb/bsm_tb_if.sv
// Testbench-side types for the box suppression bench: the stimulus transaction.
// Depends on bsm_pkg from the RTL.
`timescale 1ns / 1ps
package bsm_tb_pkg;
  import bsm_pkg::*;

  // One stimulus transaction as driven on the detection channel
  typedef struct packed {
    cmd_e               command;
    logic [6:0]         read_index;
    logic signed [12:0] rect_left;
    logic signed [12:0] rect_top;
    logic [11:0]        rect_width;
    logic [11:0]        rect_height;
    logic [15:0]        confidence;
    logic [3:0]         label;
    logic [3:0][31:0]   corner;
  } stim_t;
endpackage

FILE: tb/box_suppression_with_merge_tb.sv
// Self-checking bench for box_suppression_with_merge: random and directed frames of
// detections, reads and clears checked against an in-bench NMS/merge predictor.
// Depends on bsm_pkg, bsm_tb_pkg, bsm_in_if, bsm_out_if and the block's RTL.
`timescale 1ns / 1ps
module box_suppression_with_merge_tb;
  import bsm_pkg::*;
  import bsm_tb_pkg::*;

  localparam int DEPTH = 128;
  localparam int STALL_LIMIT = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  bsm_in_if det_ch ();
  bsm_out_if res_ch ();

  box_suppression_with_merge #(.TABLE_DEPTH(DEPTH)) uut (
    .clk_i, .rst_ni, .det_i(det_ch.sink), .res_o(res_ch.source),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Predictor copy of the configuration and table
  logic [10:0] nms_thr, merge_iou;
  logic [15:0] merge_gap;
  logic [7:0]  keep_lim;
  logic signed [12:0] tb_left [DEPTH];
  logic signed [12:0] tb_top [DEPTH];
  logic [11:0] tb_w [DEPTH];
  logic [11:0] tb_h [DEPTH];
  logic [15:0] tb_conf [DEPTH];
  logic [3:0]  tb_label [DEPTH];
  logic [3:0][47:0] tb_sum [DEPTH];
  logic [7:0]  tb_sets [DEPTH];
  int kept_cnt, seen_cnt;

  stim_t pending_q[$];
  res_t  expected_q[$];
  int errors = 0;
  int n_kept = 0, n_supp = 0, n_merge = 0, n_drop = 0, n_read = 0;
  bit stim_done = 0;
  int idle_cycles = 0;

  function automatic logic [47:0] grow(logic [31:0] c);
    logic signed [23:0] x, y;
    x = $signed(c[31:16]);
    y = $signed(c[15:0]);
    return {x, y};
  endfunction

  function automatic logic [47:0] accumulate(logic [47:0] s, logic [31:0] c);
    logic [47:0] t;
    logic [23:0] x, y;
    t = grow(c);
    x = s[47:24] + t[47:24];
    y = s[23:0] + t[23:0];
    return {x, y};
  endfunction

  // Compute the expected result of one transaction and update the table
  function automatic res_t predict_nms(stim_t d);
    res_t r;
    longint l, t, w, h, bl, bt, bw, bh, x1, y1, x2, y2, inter, uni, area, gap;
    bit keep, zu;
    int first;
    r = '0;
    first = 0;
    keep = 1;
    case (d.command)
      CMD_CLEAR: begin
        kept_cnt = 0; seen_cnt = 0;
        r.status = STS_CLEARED;
        return r;
      end
      CMD_READ: begin
        r.entry_index = d.read_index;
        if (d.read_index >= kept_cnt) begin
          r.status = STS_BAD_INDEX;
          return r;
        end
        n_read++;
        r.status = STS_READ;
        r.set_count = tb_sets[d.read_index];
        r.corner_sum = tb_sum[d.read_index];
        r.entry_confidence = tb_conf[d.read_index];
        r.entry_label = tb_label[d.read_index];
        return r;
      end
      default: ;
    endcase
    if (seen_cnt >= keep_lim) begin
      r.status = STS_DROPPED;
      n_drop++;
      return r;
    end
    if (seen_cnt < 255) seen_cnt++;
    l = d.rect_left; t = d.rect_top; w = d.rect_width; h = d.rect_height;
    area = w * h;
    for (int j = 0; j < kept_cnt; j++) begin
      bl = tb_left[j]; bt = tb_top[j]; bw = tb_w[j]; bh = tb_h[j];
      x1 = (l > bl) ? l : bl;
      y1 = (t > bt) ? t : bt;
      x2 = (l + w < bl + bw) ? l + w : bl + bw;
      y2 = (t + h < bt + bh) ? t + h : bt + bh;
      inter = (x2 > x1 && y2 > y1) ? (x2 - x1) * (y2 - y1) : 0;
      uni = area + ((bw * bh) & 64'hFFFFFF) - inter;
      zu = (uni == 0);
      if (zu || inter * 1024 > longint'(nms_thr) * uni) begin
        if (keep) first = j;
        keep = 0;
        gap = (d.confidence > tb_conf[j]) ? d.confidence - tb_conf[j]
                                          : tb_conf[j] - d.confidence;
        if (!zu && inter * 1024 > longint'(merge_iou) * uni && gap < merge_gap &&
            d.label == tb_label[j]) begin
          for (int c = 0; c < 4; c++) tb_sum[j][c] = accumulate(tb_sum[j][c], d.corner[c]);
          if (tb_sets[j] < 255) tb_sets[j]++;
          n_merge++;
        end
      end
    end
    if (!keep) begin
      r.status = STS_SUPPRESSED;
      r.entry_index = first[6:0];
      n_supp++;
      return r;
    end
    if (kept_cnt >= DEPTH) begin
      r.status = STS_DROPPED;
      n_drop++;
      return r;
    end
    tb_left[kept_cnt] = d.rect_left; tb_top[kept_cnt] = d.rect_top;
    tb_w[kept_cnt] = d.rect_width; tb_h[kept_cnt] = d.rect_height;
    tb_conf[kept_cnt] = d.confidence; tb_label[kept_cnt] = d.label;
    for (int c = 0; c < 4; c++) tb_sum[kept_cnt][c] = grow(d.corner[c]);
    tb_sets[kept_cnt] = 1;
    r.status = STS_KEPT;
    r.entry_index = kept_cnt[6:0];
    kept_cnt++;
    n_kept++;
    return r;
  endfunction

  // Driver: bursts with random gaps
  int burst_left = 0, gap_left = 0;
  initial begin
    det_ch.valid = 0; det_ch.command = '0; det_ch.read_index = '0;
    det_ch.rect_left = '0; det_ch.rect_top = '0; det_ch.rect_width = '0;
    det_ch.rect_height = '0; det_ch.confidence = '0; det_ch.label = '0;
    det_ch.corner0 = '0; det_ch.corner1 = '0; det_ch.corner2 = '0; det_ch.corner3 = '0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      stim_t d;
      bit fire, load;
      fire = det_ch.valid && det_ch.ready;
      if (fire) begin
        d = pending_q.pop_front();
        if (d.command != CMD_NONE) expected_q = {expected_q, predict_nms(d)};
      end
      load = 0;
      if (!det_ch.valid || fire) begin
        if (gap_left > 0) gap_left--;
        else if (pending_q.size() > 0) begin
          load = 1;
          if (burst_left > 0) burst_left--;
          else begin
            burst_left = $urandom_range(0, 12);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
          end
        end
        det_ch.valid <= load;
        if (load) begin
          d = pending_q[0];
          det_ch.command <= d.command; det_ch.read_index <= d.read_index;
          det_ch.rect_left <= d.rect_left; det_ch.rect_top <= d.rect_top;
          det_ch.rect_width <= d.rect_width; det_ch.rect_height <= d.rect_height;
          det_ch.confidence <= d.confidence; det_ch.label <= d.label;
          det_ch.corner0 <= d.corner[0]; det_ch.corner1 <= d.corner[1];
          det_ch.corner2 <= d.corner[2]; det_ch.corner3 <= d.corner[3];
        end
      end
    end
  end

  // Monitor: receiver stall pattern and field checks
  initial res_ch.ready = 0;
  int stall_phase = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      res_t e;
      if ((det_ch.valid && det_ch.ready) || (res_ch.valid && res_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (res_ch.valid && res_ch.ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: result with nothing expected, actual status %0d", $time,
                   res_ch.status);
          errors++;
        end else begin
          e = expected_q.pop_front();
          if (res_ch.status !== e.status || res_ch.entry_index !== e.entry_index ||
              res_ch.set_count !== e.set_count ||
              res_ch.corner0_sum !== e.corner_sum[0] ||
              res_ch.corner1_sum !== e.corner_sum[1] ||
              res_ch.corner2_sum !== e.corner_sum[2] ||
              res_ch.corner3_sum !== e.corner_sum[3] ||
              res_ch.entry_confidence !== e.entry_confidence ||
              res_ch.entry_label !== e.entry_label) begin
            $display("%0t: mismatch expected st=%0d idx=%0d cnt=%0d s=%h %h %h %h c=%h l=%h",
                     $time, e.status, e.entry_index, e.set_count, e.corner_sum[0],
                     e.corner_sum[1], e.corner_sum[2], e.corner_sum[3],
                     e.entry_confidence, e.entry_label);
            $display("%0t:          actual   st=%0d idx=%0d cnt=%0d s=%h %h %h %h c=%h l=%h",
                     $time, res_ch.status, res_ch.entry_index, res_ch.set_count,
                     res_ch.corner0_sum, res_ch.corner1_sum, res_ch.corner2_sum,
                     res_ch.corner3_sum, res_ch.entry_confidence, res_ch.entry_label);
            errors++;
          end
        end
      end
      // long ready stretches alternate with choppy stalls
      stall_phase = (stall_phase + 1) % 400;
      if (stall_phase < 150) res_ch.ready <= 1'b1;
      else if (stall_phase < 300) res_ch.ready <= ($urandom_range(0, 3) != 0);
      else res_ch.ready <= ($urandom_range(0, 4) == 0);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    if (idle_cycles > STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk_i);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (idx)
      REG_NMS_THR:   nms_thr = val[10:0];
      REG_MERGE_IOU: merge_iou = val[10:0];
      REG_MERGE_GAP: merge_gap = val[15:0];
      default:       keep_lim = val[7:0];
    endcase
  endtask

  task automatic wait_drained();
    while (pending_q.size() > 0 || expected_q.size() > 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
  endtask

  function automatic stim_t make_cmd(cmd_e c, logic [6:0] idx);
    stim_t d;
    d = '0;
    d.command = c;
    d.read_index = idx;
    return d;
  endfunction

  function automatic stim_t rand_det(bit near, stim_t base);
    stim_t d;
    d.command = CMD_DETECT;
    d.read_index = 7'($urandom);
    for (int c = 0; c < 4; c++) d.corner[c] = $urandom;
    d.label = 4'(near && $urandom_range(0, 2) != 0 ? 32'(base.label) : $urandom);
    if (near) begin
      d.rect_left = 13'(base.rect_left + $signed($urandom_range(0, 6)) - 3);
      d.rect_top = 13'(base.rect_top + $signed($urandom_range(0, 6)) - 3);
      d.rect_width = 12'(base.rect_width + $urandom_range(0, 4));
      d.rect_height = 12'(base.rect_height + $urandom_range(0, 4));
      d.confidence = 16'(base.confidence - $urandom_range(0, 12000));
    end else if ($urandom_range(0, 9) == 0) begin
      d.rect_left = 13'($urandom); d.rect_top = 13'($urandom);
      d.rect_width = 12'($urandom); d.rect_height = 12'($urandom);
      d.confidence = 16'($urandom);
    end else begin
      d.rect_left = 13'($urandom_range(0, 400)); d.rect_top = 13'($urandom_range(0, 400));
      d.rect_width = 12'($urandom_range(0, 80)); d.rect_height = 12'($urandom_range(0, 80));
      d.confidence = 16'($urandom);
    end
    return d;
  endfunction

  // Queue one frame: clear, detections (clusters of near boxes), reads and an occasional command 3
  task automatic add_frame(int n_det);
    stim_t base, d;
    pending_q = {pending_q, make_cmd(CMD_CLEAR, '0)};
    base = rand_det(0, base);
    for (int i = 0; i < n_det; i++) begin
      if ($urandom_range(0, 2) == 0) begin
        base = rand_det(0, base);
        d = base;
      end else d = rand_det(1, base);
      pending_q = {pending_q, d};
      if ($urandom_range(0, 7) == 0)
        pending_q = {pending_q, make_cmd(CMD_READ, 7'($urandom_range(0, 20)))};
    end
    for (int i = 0; i < 6; i++)
      pending_q = {pending_q, make_cmd($urandom_range(0, 15) == 0 ? CMD_NONE : CMD_READ,
                                       7'($urandom_range(0, 40)))};
  endtask

  initial begin
    stim_t d;
    int sent;
    nms_thr = 307; merge_iou = 922; merge_gap = 9830; keep_lim = 128;
    kept_cnt = 0; seen_cnt = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, every command, zero union, bad index, command 3
    pending_q = {pending_q, make_cmd(CMD_CLEAR, 7'd0)};
    pending_q = {pending_q, make_cmd(CMD_READ, 7'd0)};
    d = '0; d.command = CMD_DETECT; d.rect_left = 13'(-4096); d.rect_top = 13'(-4096);
    d.rect_width = 12'd4095; d.rect_height = 12'd4095; d.confidence = 16'hFFFF;
    d.label = 4'd15;
    d.corner = {32'hFFFF_FFFF, 32'h8000_8000, 32'h7FFF_7FFF, 32'h0001_FFFF};
    pending_q = {pending_q, d};
    pending_q = {pending_q, d};
    d.rect_left = 13'd4095; d.rect_top = 13'd4095; d.rect_width = '0; d.rect_height = '0;
    pending_q = {pending_q, d};
    pending_q = {pending_q, d};
    d.rect_left = 13'd10; d.rect_top = 13'd10; d.rect_width = 12'd20; d.rect_height = 12'd20;
    d.label = '0; d.confidence = '0; d.corner = '0;
    pending_q = {pending_q, d};
    pending_q = {pending_q, make_cmd(CMD_READ, 7'd0)};
    pending_q = {pending_q, make_cmd(CMD_READ, 7'd1)};
    pending_q = {pending_q, make_cmd(CMD_READ, 7'd127)};
    pending_q = {pending_q, make_cmd(CMD_NONE, 7'd5)};
    pending_q = {pending_q, make_cmd(CMD_READ, 7'd2)};
    wait_drained();

    // Phases through several register settings, extremes included
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin cfg_write(REG_NMS_THR, 0); cfg_write(REG_MERGE_IOU, 0);
                 cfg_write(REG_MERGE_GAP, 65535); cfg_write(REG_KEEP_LIM, 128); end
        1: begin cfg_write(REG_NMS_THR, 1024); cfg_write(REG_MERGE_IOU, 1024);
                 cfg_write(REG_MERGE_GAP, 0); cfg_write(REG_KEEP_LIM, 1); end
        2: begin cfg_write(REG_NMS_THR, 307); cfg_write(REG_MERGE_IOU, 922);
                 cfg_write(REG_MERGE_GAP, 9830); cfg_write(REG_KEEP_LIM, 20); end
        3: cfg_write(REG_KEEP_LIM, 0);
        4: begin cfg_write(REG_KEEP_LIM, 255); cfg_write(REG_NMS_THR, 1024); end
        default: begin
          cfg_write(REG_NMS_THR, $urandom_range(100, 700));
          cfg_write(REG_MERGE_IOU, $urandom_range(300, 1000));
          cfg_write(REG_MERGE_GAP, $urandom);
          cfg_write(REG_KEEP_LIM, $urandom_range(1, 128));
        end
      endcase
      sent = 0;
      while (sent < (ph == 4 ? 160 : 100)) begin
        add_frame(ph == 4 ? 150 : $urandom_range(3, 30));
        sent += (ph == 4) ? 160 : 25;
      end
      wait_drained();
    end
    stim_done = 1;

    $display("Covered: %0d kept, %0d suppressed, %0d merges, %0d dropped, %0d entry reads",
             n_kept, n_supp, n_merge, n_drop, n_read);
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule

FILE: filelist.f
hdl/bsm_pkg.sv
hdl/bsm_in_if.sv
hdl/bsm_out_if.sv
hdl/bsm_ram.sv
hdl/bsm_iou.sv
hdl/box_suppression_with_merge.sv
tb/bsm_tb_if.sv
tb/box_suppression_with_merge_tb.sv
